// ===== design/tlg_pkg.sv =====
// Shared types and constants for the toroidal Life generation block.
package tlg_pkg;

  // Grid geometry: square grid, one row per item.
  localparam int GRID_SIDE = 16;
  localparam int ROW_W     = 16;
  localparam int NUM_W     = 4;
  localparam int GEN_W     = 16;
  localparam int CNT_W     = 4;

  localparam logic [NUM_W-1:0] LAST_ROW  = NUM_W'(GRID_SIDE - 1);
  localparam logic [GEN_W-1:0] GEN_RESET = GEN_W'(64);

  // Neighbor counts that keep or create a live cell.
  localparam logic [CNT_W-1:0] BIRTH_COUNT = CNT_W'(3);
  localparam logic [CNT_W-1:0] KEEP_COUNT  = CNT_W'(2);

  typedef logic [ROW_W-1:0] row_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_LOAD = 3'b001,
    ST_RUN  = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

endpackage

// ===== design/tlg_row_unit.sv =====
// Shared row unit: computes the next generation of one row from its old neighbors.
module tlg_row_unit
  import tlg_pkg::*;
(
  input  row_t up_row,
  input  row_t cur_row,
  input  row_t dn_row,
  output row_t next_row
);

  row_t up_l, up_r, cur_l, cur_r, dn_l, dn_r;

  // Wrapped column neighbors: the left one holds column c-1, the right one c+1.
  assign up_l  = {up_row[ROW_W-2:0], up_row[ROW_W-1]};
  assign up_r  = {up_row[0], up_row[ROW_W-1:1]};
  assign cur_l = {cur_row[ROW_W-2:0], cur_row[ROW_W-1]};
  assign cur_r = {cur_row[0], cur_row[ROW_W-1:1]};
  assign dn_l  = {dn_row[ROW_W-2:0], dn_row[ROW_W-1]};
  assign dn_r  = {dn_row[0], dn_row[ROW_W-1:1]};

  // Each column counts its eight neighbors and applies the Life rule.
  always_comb begin
    logic [CNT_W-1:0] n;
    for (int c = 0; c < ROW_W; c++) begin
      n = CNT_W'(up_l[c]) + CNT_W'(up_row[c]) + CNT_W'(up_r[c])
        + CNT_W'(cur_l[c]) + CNT_W'(cur_r[c])
        + CNT_W'(dn_l[c]) + CNT_W'(dn_row[c]) + CNT_W'(dn_r[c]);
      next_row[c] = (n == BIRTH_COUNT) || (cur_row[c] && (n == KEEP_COUNT));
    end
  end

endmodule

// ===== design/toroidal_life_generation.sv =====
// Top level of the toroidal Life generation block: row store, sequencer and output register.
//
//   Channel   Ports                                          Direction
//   input     in_valid, in_ready, in_row_cells               one grid row per item
//   result    out_valid, out_ready, out_result_row,          one final row per item
//             out_result_row_number, out_final_row
//   config    cfg_wr_en, cfg_wr_data                         generation count
//
// Rows 0 to 14 are each stored as they arrive and give no result.
// After row 15 the block is busy for generation_count generations: the shared
// row unit computes one new row per cycle while the row store rotates once per
// generation. The 16 result items then leave one per cycle while out_ready is high.
// A stalled result channel holds the sequencer; rst_n is synchronous and active low.
module toroidal_life_generation
  import tlg_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [GEN_W-1:0] cfg_wr_data,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [ROW_W-1:0] in_row_cells,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [ROW_W-1:0] out_result_row,
  output logic [NUM_W-1:0] out_result_row_number,
  output logic             out_final_row
);

  state_t           state_r, state_nxt;
  logic [GEN_W-1:0] gen_count_r, gen_count_nxt;
  logic [GEN_W-1:0] gen_left_r, gen_left_nxt;
  logic [NUM_W-1:0] row_cnt_r, row_cnt_nxt;
  row_t             grid_r [GRID_SIDE];
  row_t             grid_nxt [GRID_SIDE];
  row_t             prev_old_r, prev_old_nxt;
  row_t             first_old_r, first_old_nxt;
  logic             out_valid_r, out_valid_nxt;
  row_t             out_row_r, out_row_nxt;
  logic [NUM_W-1:0] out_num_r, out_num_nxt;
  logic             out_final_r, out_final_nxt;

  logic in_accept;
  logic emit_go;
  logic last_row;
  row_t up_row, dn_row, new_row;

  assign in_ready  = (state_r == ST_LOAD);
  assign in_accept = in_valid && in_ready;
  assign emit_go   = (state_r == ST_EMIT) && (!out_valid_r || out_ready);
  assign last_row  = (row_cnt_r == LAST_ROW);

  // Old neighbors of the front row: wrap to the old last row at row 0 and to
  // the saved old row 0 at the last row.
  assign up_row = (row_cnt_r == '0) ? grid_r[GRID_SIDE-1] : prev_old_r;
  assign dn_row = last_row ? first_old_r : grid_r[1];

  tlg_row_unit u_row_unit (
    .up_row   (up_row),
    .cur_row  (grid_r[0]),
    .dn_row   (dn_row),
    .next_row (new_row)
  );

  // Sequencer, counters and row store next state.
  always_comb begin
    state_nxt     = state_r;
    gen_count_nxt = cfg_wr_en ? cfg_wr_data : gen_count_r;
    gen_left_nxt  = gen_left_r;
    row_cnt_nxt   = row_cnt_r;
    grid_nxt      = grid_r;
    prev_old_nxt  = prev_old_r;
    first_old_nxt = first_old_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_row_nxt   = out_row_r;
    out_num_nxt   = out_num_r;
    out_final_nxt = out_final_r;

    unique case (state_r)
      ST_LOAD: begin
        if (in_accept) begin
          for (int i = 0; i < GRID_SIDE - 1; i++) begin
            grid_nxt[i] = grid_r[i+1];
          end
          grid_nxt[GRID_SIDE-1] = in_row_cells;
          row_cnt_nxt           = row_cnt_r + NUM_W'(1);
          if (last_row) begin
            gen_left_nxt = gen_count_r;
            state_nxt    = (gen_count_r == '0) ? ST_EMIT : ST_RUN;
          end
        end
      end
      ST_RUN: begin
        // One row per cycle; the new row enters at the back of the store.
        for (int i = 0; i < GRID_SIDE - 1; i++) begin
          grid_nxt[i] = grid_r[i+1];
        end
        grid_nxt[GRID_SIDE-1] = new_row;
        prev_old_nxt          = grid_r[0];
        if (row_cnt_r == '0) begin
          first_old_nxt = grid_r[0];
        end
        row_cnt_nxt = row_cnt_r + NUM_W'(1);
        if (last_row) begin
          gen_left_nxt = gen_left_r - GEN_W'(1);
          if (gen_left_r == GEN_W'(1)) begin
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (emit_go) begin
          for (int i = 0; i < GRID_SIDE - 1; i++) begin
            grid_nxt[i] = grid_r[i+1];
          end
          grid_nxt[GRID_SIDE-1] = grid_r[0];
          out_valid_nxt         = 1'b1;
          out_row_nxt           = grid_r[0];
          out_num_nxt           = row_cnt_r;
          out_final_nxt         = last_row;
          row_cnt_nxt           = row_cnt_r + NUM_W'(1);
          if (last_row) begin
            state_nxt = ST_LOAD;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      gen_count_r <= GEN_RESET;
      gen_left_r  <= '0;
      row_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      gen_count_r <= gen_count_nxt;
      gen_left_r  <= gen_left_nxt;
      row_cnt_r   <= row_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    grid_r      <= grid_nxt;
    prev_old_r  <= prev_old_nxt;
    first_old_r <= first_old_nxt;
    out_row_r   <= out_row_nxt;
    out_num_r   <= out_num_nxt;
    out_final_r <= out_final_nxt;
  end

  assign out_valid             = out_valid_r;
  assign out_result_row        = out_row_r;
  assign out_result_row_number = out_num_r;
  assign out_final_row         = out_final_r;

  // The last item of a grid always carries the last row number.
  a_final_number: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_final_r |-> out_num_r == LAST_ROW)
    else $error("final row flag on a row other than the last");

  // A generation pass never runs with no generations left.
  a_run_left: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RUN |-> gen_left_r != '0)
    else $error("generation pass with zero generations left");

  // Leaving the emit phase leaves the row counter at row 0 for the next grid.
  a_emit_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EMIT && emit_go && last_row |=> row_cnt_r == '0 && state_r == ST_LOAD)
    else $error("row counter not back at row 0 after the emit phase");

endmodule
